// File: sv/sat_pkg.sv
// shared types and constants for the sampled allocation tracker
`timescale 1ns / 1ps
package sat_pkg;
   localparam int unsigned TABLE_DEPTH_DEF = 4096;
   localparam int unsigned PROBE_LIMIT_DEF = 256;
   localparam int unsigned STACK_SLOTS_DEF = 65536;

   localparam logic [63:0] MIX_MUL = 64'hff51afd7ed558ccd;
   localparam int unsigned MIX_SHIFT = 33;

   localparam int unsigned ADDR_W = 64;
   localparam int unsigned SIZE_W = 48;
   localparam int unsigned STACK_W = 16;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned SLOT_W = 12;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 48;
   localparam int unsigned ACC_W = 49;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIG_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_INTERVAL = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_IGNORED = 3'd0,
      ST_BIG = 3'd1,
      ST_SAMPLED = 3'd2,
      ST_FULL = 3'd3,
      ST_REMOVED = 3'd4,
      ST_NOT_FOUND = 3'd5
   } status_type;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BIG = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SAMPLED = 2'd2;

   typedef enum logic [1:0] {
      OP_IGNORE = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type op;
      logic sampled;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] size;
      logic [STACK_W-1:0] stack;
   } cmd_type;
endpackage

// File: sv/sat_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module sat_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: sv/sat_front.sv
// front end: classifies transactions, hashes address, keeps the byte count for sampling
`timescale 1ns / 1ps
module sat_front #(
   parameter int unsigned TABLE_DEPTH = 4096,
   parameter int unsigned STACK_SLOTS = 65536
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [sat_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic [63:0] req_address,
   input  logic [47:0] req_alloc_size,
   input  logic [15:0] req_stack_id,
   output logic cmd_valid,
   input  logic cmd_stall,
   output sat_pkg::cmd_type cmd,
   output logic [$clog2(TABLE_DEPTH)-1:0] cmd_home
);
   import sat_pkg::*;
   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned SK_W = $clog2(STACK_SLOTS);

   logic enable_ff;
   logic [SIZE_W-1:0] threshold_ff;
   logic [31:0] interval_ff;
   logic [ACC_W-1:0] acc_ff, acc_in;

   // stage 1: capture and premix; stage 2: partial products; stage 3: output
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   cmd_type s1_cmd_ff, s2_cmd_ff, out_cmd_ff, s1_cmd_in;
   logic [63:0] s1_h_ff, s2_ll_ff, s2_prod;
   logic [31:0] s2_lh_ff, s2_hl_ff;
   logic [IDX_W-1:0] out_home_ff;
   logic [63:0] h2;
   logic busy;
   logic [ACC_W-1:0] acc_sum;

   assign busy = s1_valid_ff || s2_valid_ff || out_valid_ff;
   assign req_stall = busy;
   assign cmd_valid = out_valid_ff;
   assign cmd = out_cmd_ff;
   assign cmd_home = out_home_ff;
   // low 64 bits of the product from three 32 by 32 partial products
   assign s2_prod = s2_ll_ff + {s2_lh_ff + s2_hl_ff, 32'd0};
   assign h2 = s2_prod ^ (s2_prod >> MIX_SHIFT);

   always_comb begin
      acc_sum = acc_ff + ACC_W'(req_alloc_size);
      acc_in = acc_ff;
      s1_cmd_in.op = OP_IGNORE;
      s1_cmd_in.sampled = 1'b0;
      s1_cmd_in.address = req_address;
      s1_cmd_in.size = req_alloc_size;
      s1_cmd_in.stack = STACK_W'(req_stack_id[SK_W-1:0]);
      if (enable_ff && req_address != '0) begin
         if (req_action) begin
            s1_cmd_in.op = OP_REMOVE;
         end else if (req_alloc_size >= threshold_ff) begin
            s1_cmd_in.op = OP_INSERT;
         end else if (acc_sum < ACC_W'(interval_ff)) begin
            acc_in = acc_sum;
         end else begin
            acc_in = '0;
            s1_cmd_in.op = OP_INSERT;
            s1_cmd_in.sampled = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         threshold_ff <= SIZE_W'(32768);
         interval_ff <= 32'd1048576;
         acc_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ENABLE: enable_ff <= csr_data[0];
               CSR_BIG_THRESHOLD: threshold_ff <= csr_data;
               CSR_SAMPLE_INTERVAL: interval_ff <= csr_data[31:0];
               default: ;
            endcase
         end
         if (req_valid && !busy) begin
            acc_ff <= acc_in;
         end
         s1_valid_ff <= req_valid && !busy;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff) begin
            out_valid_ff <= 1'b1;
         end else if (!cmd_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_valid && !busy) begin
         s1_cmd_ff <= s1_cmd_in;
         s1_h_ff <= req_address ^ (req_address >> MIX_SHIFT);
      end
      s2_cmd_ff <= s1_cmd_ff;
      s2_ll_ff <= s1_h_ff[31:0] * MIX_MUL[31:0];
      s2_lh_ff <= 32'(s1_h_ff[31:0] * MIX_MUL[63:32]);
      s2_hl_ff <= 32'(s1_h_ff[63:32] * MIX_MUL[31:0]);
      if (s2_valid_ff) begin
         out_cmd_ff <= s2_cmd_ff;
         out_home_ff <= h2[IDX_W-1:0];
      end
   end

`ifndef NO_ASSERTIONS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !s2_valid_ff && !out_valid_ff)
      else $error("front overlap");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_home))
      else $error("command dropped");
   a_acc_idle: assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(acc_ff))
      else $error("accumulator moved while busy");
`endif
endmodule

// File: sv/sat_back.sv
// back end: walks the probe run in the table and forms the result
`timescale 1ns / 1ps
module sat_back #(
   parameter int unsigned TABLE_DEPTH = 4096,
   parameter int unsigned PROBE_LIMIT = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_stall,
   input  sat_pkg::cmd_type cmd,
   input  logic [$clog2(TABLE_DEPTH)-1:0] cmd_home,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [11:0] rsp_slot_index,
   output logic [47:0] rsp_removed_size,
   output logic [15:0] rsp_removed_stack,
   output logic [1:0] rsp_removed_kind
);
   import sat_pkg::*;
   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned PC_W = $clog2(PROBE_LIMIT + 1);
   localparam int unsigned DATA_W = SIZE_W + STACK_W + 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_CHECK, S_OUT
   } state_type;

   state_type state_ff;
   cmd_type cmd_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [PC_W-1:0] probes_ff;
   logic clr_last_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [11:0] slot_ff;
   logic [SIZE_W-1:0] rsize_ff;
   logic [STACK_W-1:0] rstack_ff;
   logic [KIND_W-1:0] rkind_ff;

   logic addr_we, data_we;
   logic [IDX_W-1:0] ram_addr;
   logic [ADDR_W-1:0] addr_wd, addr_rd;
   logic [DATA_W-1:0] data_rd;

   always_comb begin
      addr_we = 1'b0;
      data_we = 1'b0;
      addr_wd = '0;
      ram_addr = idx_ff;
      if (state_ff == S_CLEAR) begin
         addr_we = 1'b1;
      end else if (state_ff == S_CHECK) begin
         if (cmd_ff.op == OP_INSERT && addr_rd == '0) begin
            addr_we = 1'b1;
            data_we = 1'b1;
            addr_wd = cmd_ff.address;
         end else if (cmd_ff.op == OP_REMOVE && addr_rd == cmd_ff.address) begin
            addr_we = 1'b1;
         end
      end
   end

   sat_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_addr (
      .clock(clock), .wr_en(addr_we), .addr(ram_addr),
      .wr_data(addr_wd), .rd_data(addr_rd));
   sat_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_data (
      .clock(clock), .wr_en(data_we), .addr(ram_addr),
      .wr_data({cmd_ff.size, cmd_ff.stack, cmd_ff.sampled}), .rd_data(data_rd));

   assign cmd_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = status_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_removed_size = rsize_ff;
   assign rsp_removed_stack = rstack_ff;
   assign rsp_removed_kind = rkind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         clr_last_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
               clr_last_ff <= (idx_ff == IDX_W'(TABLE_DEPTH - 2));
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd;
                  idx_ff <= cmd_home;
                  probes_ff <= '0;
                  status_ff <= ST_IGNORED;
                  slot_ff <= '0;
                  rsize_ff <= '0;
                  rstack_ff <= '0;
                  rkind_ff <= KIND_NONE;
                  state_ff <= (cmd.op == OP_IGNORE) ? S_OUT : S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (cmd_ff.op == OP_INSERT && addr_rd == '0) begin
                  status_ff <= cmd_ff.sampled ? ST_SAMPLED : ST_BIG;
                  slot_ff <= 12'(idx_ff);
                  state_ff <= S_OUT;
               end else if (cmd_ff.op == OP_REMOVE && addr_rd == cmd_ff.address) begin
                  status_ff <= ST_REMOVED;
                  slot_ff <= 12'(idx_ff);
                  rsize_ff <= data_rd[DATA_W-1 -: SIZE_W];
                  rstack_ff <= data_rd[STACK_W:1];
                  rkind_ff <= data_rd[0] ? KIND_SAMPLED : KIND_BIG;
                  state_ff <= S_OUT;
               end else if (probes_ff == PC_W'(PROBE_LIMIT - 1)) begin
                  status_ff <= (cmd_ff.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                  state_ff <= S_OUT;
               end else begin
                  probes_ff <= probes_ff + 1'b1;
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid)
      else $error("response during clear");
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> probes_ff < PC_W'(PROBE_LIMIT))
      else $error("probe count overrun");
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR && clr_last_ff |=> state_ff == S_IDLE)
      else $error("clear pass end");
   a_write_found: assert property (@(posedge clock) disable iff (reset)
      data_we |=> state_ff == S_OUT)
      else $error("stray data write");
`endif
endmodule

// File: sv/sampled_allocation_tracker_top.sv
// top level of the sampled allocation tracker
// front: capture, partial-product and output registers (hash and classify); back: read and check per probe, then out
// the back end takes one transaction at a time, and the front takes no new request while any
// of its stages holds one
// the probe walk over the address ram reads and checks one slot at a time
// reset: synchronous; a clear pass over all TABLE_DEPTH slots empties the address ram,
// and the back end takes no transaction until it is done
`timescale 1ns / 1ps
module sampled_allocation_tracker_top #(
   parameter int unsigned TABLE_DEPTH = sat_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned PROBE_LIMIT = sat_pkg::PROBE_LIMIT_DEF,
   parameter int unsigned STACK_SLOTS = sat_pkg::STACK_SLOTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [sat_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic [63:0] req_address,
   input  logic [47:0] req_alloc_size,
   input  logic [15:0] req_stack_id,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [11:0] rsp_slot_index,
   output logic [47:0] rsp_removed_size,
   output logic [15:0] rsp_removed_stack,
   output logic [1:0] rsp_removed_kind
);
   import sat_pkg::*;
   logic cmd_valid, cmd_stall;
   cmd_type cmd;
   logic [$clog2(TABLE_DEPTH)-1:0] cmd_home;

   sat_front #(.TABLE_DEPTH(TABLE_DEPTH), .STACK_SLOTS(STACK_SLOTS)) u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_action, .req_address, .req_alloc_size,
      .req_stack_id, .cmd_valid, .cmd_stall, .cmd, .cmd_home);

   sat_back #(.TABLE_DEPTH(TABLE_DEPTH), .PROBE_LIMIT(PROBE_LIMIT)) u_back (
      .clock, .reset, .cmd_valid, .cmd_stall, .cmd, .cmd_home,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_slot_index, .rsp_removed_size,
      .rsp_removed_stack, .rsp_removed_kind);
endmodule

// File: dv/sampled_allocation_tracker_top_test.sv
// testbench for the sampled allocation tracker: directed table, full probe run, random phases
`timescale 1ns / 1ps
module sampled_allocation_tracker_top_test;
   import sat_pkg::*;

   localparam int unsigned RUN_LIMIT = 3000000;
   localparam int unsigned HOLD_CYCLES = 2500;
   localparam int unsigned RUN_FREES = 20;

   typedef struct {
      status_type st;
      logic [11:0] slot;
      logic [47:0] size;
      logic [15:0] stack;
      logic [1:0] kind;
   } track_result_type;

   typedef struct {
      bit is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DATA_W-1:0] data;
      bit act;
      logic [63:0] addr;
      logic [47:0] size;
      logic [15:0] stack;
      bit typed;
      status_type st;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic req_valid;
   logic req_stall;
   logic req_action;
   logic [63:0] req_address;
   logic [47:0] req_alloc_size;
   logic [15:0] req_stack_id;
   logic rsp_valid;
   logic rsp_stall;
   logic [2:0] rsp_status;
   logic [11:0] rsp_slot_index;
   logic [47:0] rsp_removed_size;
   logic [15:0] rsp_removed_stack;
   logic [1:0] rsp_removed_kind;

   // tracker image
   logic [63:0] tbl_addr [TABLE_DEPTH_DEF];
   logic [47:0] tbl_size [TABLE_DEPTH_DEF];
   logic [15:0] tbl_stack [TABLE_DEPTH_DEF];
   bit tbl_sampled [TABLE_DEPTH_DEF];
   logic [ACC_W-1:0] byte_acc;
   bit cfg_enable;
   logic [47:0] cfg_threshold;
   logic [31:0] cfg_interval;
   logic [63:0] mul_inverse;

   track_result_type expected_q[$];
   stim_row_type stim_rows[$];
   logic [63:0] live_addrs[$];
   int unsigned cycles;
   int unsigned errors;
   int unsigned rsp_seen;
   int unsigned status_seen [6];
   bit hold_request;

   sampled_allocation_tracker_top uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_address(req_address), .req_alloc_size(req_alloc_size),
      .req_stack_id(req_stack_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_slot_index(rsp_slot_index), .rsp_removed_size(rsp_removed_size),
      .rsp_removed_stack(rsp_removed_stack), .rsp_removed_kind(rsp_removed_kind)
   );

   always #6 clock = ~clock;

   function automatic logic [11:0] home_of(logic [63:0] a);
      logic [63:0] h;
      h = a ^ (a >> MIX_SHIFT);
      h = h * MIX_MUL;
      h = h ^ (h >> MIX_SHIFT);
      return h[11:0];
   endfunction

   // build an address whose home slot is the given one by undoing the mix
   function automatic logic [63:0] addr_at_slot(logic [11:0] slot);
      logic [63:0] h;
      h = {$urandom, $urandom};
      h[11:0] = slot;
      h[12] = 1'b1;
      h = h ^ (h >> MIX_SHIFT);
      h = h * mul_inverse;
      h = h ^ (h >> MIX_SHIFT);
      return h;
   endfunction

   function automatic track_result_type track_step(bit act, logic [63:0] a, logic [47:0] sz,
                                                   logic [15:0] stk);
      track_result_type r;
      logic [11:0] h;
      logic [11:0] i;
      bit smp;
      r.st = ST_IGNORED;
      r.slot = '0;
      r.size = '0;
      r.stack = '0;
      r.kind = KIND_NONE;
      if (!cfg_enable || a == 64'd0) return r;
      h = home_of(a);
      if (!act) begin
         smp = 1'b0;
         if (sz < cfg_threshold) begin
            byte_acc = byte_acc + ACC_W'(sz);
            if (byte_acc < {17'd0, cfg_interval}) return r;
            byte_acc = '0;
            smp = 1'b1;
         end
         for (int p = 0; p < PROBE_LIMIT_DEF; p++) begin
            i = h + p[11:0];
            if (tbl_addr[i] == 64'd0) begin
               tbl_addr[i] = a;
               tbl_size[i] = sz;
               tbl_stack[i] = stk;
               tbl_sampled[i] = smp;
               r.st = smp ? ST_SAMPLED : ST_BIG;
               r.slot = i;
               return r;
            end
         end
         r.st = ST_FULL;
         return r;
      end
      for (int p = 0; p < PROBE_LIMIT_DEF; p++) begin
         i = h + p[11:0];
         if (tbl_addr[i] == a) begin
            tbl_addr[i] = 64'd0;
            r.st = ST_REMOVED;
            r.slot = i;
            r.size = tbl_size[i];
            r.stack = tbl_stack[i];
            r.kind = tbl_sampled[i] ? KIND_SAMPLED : KIND_BIG;
            return r;
         end
      end
      r.st = ST_NOT_FOUND;
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = data;
      row.act = 1'b0;
      row.addr = '0;
      row.size = '0;
      row.stack = '0;
      row.typed = 1'b0;
      row.st = ST_IGNORED;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_txn(bit act, logic [63:0] a, logic [47:0] sz, logic [15:0] stk,
                                   bit typed, status_type st);
      stim_row_type row;
      row.is_csr = 1'b0;
      row.idx = '0;
      row.data = '0;
      row.act = act;
      row.addr = a;
      row.size = sz;
      row.stack = stk;
      row.typed = typed;
      row.st = st;
      stim_rows.push_back(row);
   endfunction

   // one transaction on the request side, with a possible typed expectation
   task automatic send_txn(bit act, logic [63:0] a, logic [47:0] sz, logic [15:0] stk,
                           bit typed, status_type st);
      track_result_type r;
      int unsigned gap;
      req_valid <= 1'b1;
      req_action <= act;
      req_address <= a;
      req_alloc_size <= sz;
      req_stack_id <= stk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = track_step(act, a, sz, stk);
      if (typed) begin
         r.st = st;
         r.slot = '0;
         r.size = '0;
         r.stack = '0;
         r.kind = KIND_NONE;
      end
      expected_q.push_back(r);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      settle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_ENABLE: cfg_enable = data[0];
         CSR_BIG_THRESHOLD: cfg_threshold = data[47:0];
         CSR_SAMPLE_INTERVAL: cfg_interval = data[31:0];
         default: ;
      endcase
   endtask

   task automatic random_phase(int unsigned count, logic [47:0] thr, logic [31:0] ivl);
      int unsigned r;
      int unsigned k;
      logic [63:0] a;
      logic [47:0] sz;
      logic [11:0] cluster;
      write_csr(CSR_BIG_THRESHOLD, thr);
      write_csr(CSR_SAMPLE_INTERVAL, {16'd0, ivl});
      cluster = 12'($urandom);
      for (int n = 0; n < count; n++) begin
         if (n == 10) hold_request = 1'b1;
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 1)) sz = 48'($urandom_range(0, 4096));
         else sz = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
         if (r < 55 || live_addrs.size() == 0) begin
            if ($urandom_range(0, 3) == 0) a = addr_at_slot(cluster + 12'($urandom_range(0, 7)));
            else a = {$urandom, $urandom};
            live_addrs.push_back(a);
            send_txn(1'b0, a, sz, 16'($urandom), 1'b0, ST_IGNORED);
         end else if (r < 90) begin
            k = $urandom_range(0, live_addrs.size() - 1);
            a = live_addrs[k];
            live_addrs.delete(k);
            send_txn(1'b1, a, 48'($urandom), 16'($urandom), 1'b0, ST_IGNORED);
         end else if (r < 93) begin
            send_txn(1'($urandom_range(0, 1)), 64'd0, sz, 16'($urandom), 1'b0, ST_IGNORED);
         end else if (r < 96) begin
            send_txn(1'b1, {$urandom, $urandom}, sz, 16'($urandom), 1'b0, ST_IGNORED);
         end else begin
            a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            send_txn(1'($urandom_range(0, 1)), a, sz, 16'($urandom), 1'b0, ST_IGNORED);
         end
      end
   endtask

   initial begin
      logic [63:0] run_addrs[$];
      logic [11:0] base;
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      req_valid <= 1'b0;
      req_action <= 1'b0;
      req_address <= '0;
      req_alloc_size <= '0;
      req_stack_id <= '0;
      hold_request = 1'b0;
      foreach (tbl_addr[i]) begin
         tbl_addr[i] = '0;
         tbl_size[i] = '0;
         tbl_stack[i] = '0;
         tbl_sampled[i] = 1'b0;
      end
      byte_acc = '0;
      cfg_enable = 1'b0;
      cfg_threshold = 48'd32768;
      cfg_interval = 32'd1048576;
      mul_inverse = MIX_MUL;
      repeat (6) mul_inverse = mul_inverse * (64'd2 - MIX_MUL * mul_inverse);

      // directed table
      add_txn(1'b0, '1, '1, '1, 1'b1, ST_IGNORED);
      add_txn(1'b1, '1, '0, '0, 1'b1, ST_IGNORED);
      add_csr(CSR_ENABLE, 48'd1);
      add_txn(1'b0, 64'd0, '1, '1, 1'b1, ST_IGNORED);
      add_txn(1'b0, '1, '1, '1, 1'b0, ST_IGNORED);
      add_txn(1'b0, 64'd1, 48'd32768, 16'd0, 1'b0, ST_IGNORED);
      add_txn(1'b0, 64'd2, 48'd32767, 16'h5a5a, 1'b1, ST_IGNORED);
      add_txn(1'b0, 64'd3, 48'd1015809, 16'ha5a5, 1'b0, ST_IGNORED);
      add_txn(1'b1, '1, '0, '0, 1'b0, ST_IGNORED);
      add_txn(1'b1, 64'd1, '0, '0, 1'b0, ST_IGNORED);
      add_txn(1'b1, 64'd3, '0, '0, 1'b0, ST_IGNORED);
      add_txn(1'b1, 64'd2, '0, '0, 1'b1, ST_NOT_FOUND);
      add_txn(1'b1, 64'd0, '0, '0, 1'b1, ST_IGNORED);
      add_txn(1'b0, 64'h8000_0000_0000_0000, 48'd0, 16'd1, 1'b1, ST_IGNORED);
      add_txn(1'b0, 64'd5, 48'd40000, 16'd7, 1'b0, ST_IGNORED);
      add_txn(1'b0, 64'd5, 48'd50000, 16'd8, 1'b0, ST_IGNORED);
      add_txn(1'b1, 64'd5, '0, '0, 1'b0, ST_IGNORED);
      add_txn(1'b1, 64'd5, '0, '0, 1'b0, ST_IGNORED);
      add_txn(1'b1, 64'd5, '0, '0, 1'b1, ST_NOT_FOUND);
      add_csr(CSR_SAMPLE_INTERVAL, 48'd0);
      add_txn(1'b0, 64'h1234_5678_9abc_def0, 48'd0, 16'd9, 1'b0, ST_IGNORED);
      add_csr(CSR_BIG_THRESHOLD, 48'hffff_ffff_ffff);
      add_csr(CSR_SAMPLE_INTERVAL, 48'hffff_ffff);
      add_txn(1'b0, 64'h0f0f_0f0f_0f0f_0f0f, 48'hffff_ffff_fffe, 16'd3, 1'b0, ST_IGNORED);
      add_txn(1'b1, 64'h0f0f_0f0f_0f0f_0f0f, '0, '0, 1'b0, ST_IGNORED);
      add_csr(CSR_BIG_THRESHOLD, 48'd0);
      add_txn(1'b0, 64'h1234_5678_9abc_def0, 48'd0, 16'd2, 1'b0, ST_IGNORED);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[n]) begin
         if (stim_rows[n].is_csr) write_csr(stim_rows[n].idx, stim_rows[n].data);
         else send_txn(stim_rows[n].act, stim_rows[n].addr, stim_rows[n].size,
                       stim_rows[n].stack, stim_rows[n].typed, stim_rows[n].st);
      end

      // one probe run filled past its end, then partly emptied again
      base = 12'($urandom);
      for (int n = 0; n <= PROBE_LIMIT_DEF; n++) begin
         run_addrs.push_back(addr_at_slot(base));
         send_txn(1'b0, run_addrs[n], 48'({$urandom, $urandom}), 16'($urandom), 1'b0,
                  ST_IGNORED);
      end
      for (int n = 0; n < RUN_FREES; n++) begin
         send_txn(1'b1, run_addrs[n], '0, '0, 1'b0, ST_IGNORED);
      end

      random_phase(30, 48'd32768, 32'd4096);
      random_phase(25, 48'd1024, 32'd1);
      random_phase(25, 48'hffff_ffff_ffff, 32'd100000);
      write_csr(CSR_ENABLE, 48'd0);
      random_phase(10, 48'd65536, 32'd8192);
      write_csr(CSR_ENABLE, 48'd1);
      random_phase(25, 48'd32768, 32'd1048576);

      settle();
      repeat (20) @(posedge clock);
      $display("covered %0d results: big %0d, sampled %0d, full %0d, removed %0d",
               rsp_seen, status_seen[ST_BIG], status_seen[ST_SAMPLED], status_seen[ST_FULL],
               status_seen[ST_REMOVED]);
      $display("not found %0d, ignored %0d, over several threshold and interval settings",
               status_seen[ST_NOT_FOUND], status_seen[ST_IGNORED]);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // response stalls, with one long hold-off while requests keep coming
   initial begin
      int unsigned n;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
         end
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      track_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (rsp_status < 6) status_seen[rsp_status]++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction, status %0d", $time, rsp_status);
            errors++;
         end else begin
            e = expected_q.pop_front();
            check_field("status", 64'(e.st), 64'(rsp_status));
            check_field("slot_index", 64'(e.slot), 64'(rsp_slot_index));
            check_field("removed_size", 64'(e.size), 64'(rsp_removed_size));
            check_field("removed_stack", 64'(e.stack), 64'(rsp_removed_stack));
            check_field("removed_kind", 64'(e.kind), 64'(rsp_removed_kind));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("%0t: timeout with %0d transactions outstanding", $time, expected_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      cycles = 0;
      errors = 0;
      rsp_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
   end
endmodule
